// ----- src/bpc_pkg.sv -----
// Package for the button press classifier: payload structs, lane event
// struct, widths, register indexes and reset values. No dependencies.
package bpc_pkg;

  localparam int unsigned BTN_WIDTH        = 8;
  localparam int unsigned BUTTON_COUNT_DEF = 8;
  localparam int unsigned CNT_W            = 16;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;
  localparam logic [CNT_W-1:0] SHORT_THR_RST = 16'd5;
  localparam logic [CNT_W-1:0] LONG_THR_RST  = 16'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR  = 2'd1;

  typedef struct packed {
    logic                 do_scan;
    logic [BTN_WIDTH-1:0] pin_levels;
    logic                 clear_pressed;
    logic                 clear_released;
    logic                 clear_short;
    logic                 clear_long;
  } in_item_t;

  typedef struct packed {
    logic [BTN_WIDTH-1:0] held_now;
    logic [BTN_WIDTH-1:0] pressed_events;
    logic [BTN_WIDTH-1:0] released_events;
    logic [BTN_WIDTH-1:0] short_events;
    logic [BTN_WIDTH-1:0] long_events;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] short_thr;
    logic [CNT_W-1:0] long_thr;
  } thr_t;

  // what one button lane found on the current scan
  typedef struct packed {
    logic held;
    logic pressed_hit;
    logic released_hit;
    logic short_hit;
    logic long_hit;
  } lane_evt_t;

endpackage

// ----- src/button_press_classifier.sv -----
// Top level of the button press classifier: config registers, button lanes,
// merging stage and a two-entry output buffer. Depends on bpc_pkg,
// bpc_lane and bpc_merge.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i): one transfer per
//   scan tick or read/clear access. do_scan samples the active-low pins;
//   the clear flags wipe the matching sticky mask after it is reported.
//   Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
//   result per input transfer, in order: held mask plus the four sticky
//   masks as they stand after the scan.
//   Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): index 0 short
//   threshold, index 1 long threshold; other indexes are ignored. Write
//   only while the block is idle.
//   Latency: the result is registered, valid the cycle after a transfer
//   into an empty buffer. Throughput: one item per cycle while the buffer
//   has room; all button lanes update in parallel in the transfer cycle,
//   so nothing iterates. Stall: a two-entry output buffer holds results;
//   input ready drops only once both entries are full, and returns the
//   cycle after a result is taken.
//   Reset: counters, masks and buffer clear; thresholds go to 5 and 200.
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i
);

  thr_t      thr_q;
  logic      take;
  logic      scan;
  lane_evt_t lane_evt [BUTTON_COUNT];
  out_item_t result;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.short_thr <= SHORT_THR_RST;
      thr_q.long_thr  <= LONG_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_THR: thr_q.short_thr <= cfg_wdata_i;
        CFG_LONG_THR:  thr_q.long_thr  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign take = in_valid_i & in_ready_o;
  assign scan = take & in_data_i.do_scan;

  // one lane per button
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    bpc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scan_i (scan),
      .pin_i  (in_data_i.pin_levels[g]),
      .thr_i  (thr_q),
      .evt_o  (lane_evt[g])
    );
  end

  bpc_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (in_data_i),
    .lane_i   (lane_evt),
    .result_o (result)
  );

  // two-entry output buffer; slot 0 is the head
  out_item_t slot0_q, slot1_q;
  logic [1:0] fill_q, fill_d;
  logic       pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (fill_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign in_ready_o  = (fill_q != 2'd2);

  always_comb begin
    fill_d = fill_q;
    if (take && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !take) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // head leaves; the new result lands behind whatever remains
      slot0_q <= (take && fill_q == 2'd1) ? result : slot1_q;
      if (take && fill_q == 2'd2) begin
        slot1_q <= result;
      end
    end else if (take) begin
      if (fill_q == 2'd0) begin
        slot0_q <= result;
      end else begin
        slot1_q <= result;
      end
    end
  end

endmodule

// ----- src/bpc_lane.sv -----
// One button lane: 16-bit saturating hold counter and threshold compares.
// Depends on bpc_pkg.
module bpc_lane
  import bpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      scan_i,    // accepted item with do_scan set
  input  logic      pin_i,     // raw level, low when pressed
  input  thr_t      thr_i,
  output lane_evt_t evt_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  logic             held;
  logic             sat;

  assign held    = ~pin_i;
  assign sat     = (cnt_q == CNT_MAX);
  assign cnt_inc = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    evt_o              = '0;
    evt_o.held         = held;
    cnt_d              = cnt_q;
    if (held) begin
      if (!sat) begin
        cnt_d             = cnt_inc;
        evt_o.pressed_hit = (cnt_inc == thr_i.short_thr);
        evt_o.long_hit    = (cnt_inc == thr_i.long_thr);
      end
    end else begin
      cnt_d = '0;
      if (cnt_q >= thr_i.short_thr) begin
        evt_o.released_hit = 1'b1;
        evt_o.short_hit    = (cnt_q < thr_i.long_thr);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (scan_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/bpc_merge.sv -----
// Merging stage: gathers lane findings into masks, keeps the sticky event
// masks and applies read-and-clear. Depends on bpc_pkg.
module bpc_merge
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,                 // item transfer this cycle
  input  in_item_t  item_i,
  input  lane_evt_t lane_i [BUTTON_COUNT],
  output out_item_t result_o               // masks after the scan
);

  logic [BTN_WIDTH-1:0] held_v, press_v, rel_v, short_v, long_v;
  logic [BTN_WIDTH-1:0] held_q, press_q, rel_q, short_q, long_q;

  for (genvar g = 0; g < BTN_WIDTH; g++) begin : g_gather
    if (g < BUTTON_COUNT) begin : g_live
      assign held_v[g]  = lane_i[g].held;
      assign press_v[g] = lane_i[g].pressed_hit;
      assign rel_v[g]   = lane_i[g].released_hit;
      assign short_v[g] = lane_i[g].short_hit;
      assign long_v[g]  = lane_i[g].long_hit;
    end else begin : g_unused
      assign held_v[g]  = 1'b0;
      assign press_v[g] = 1'b0;
      assign rel_v[g]   = 1'b0;
      assign short_v[g] = 1'b0;
      assign long_v[g]  = 1'b0;
    end
  end

  always_comb begin
    result_o = '{held_now: held_q, pressed_events: press_q, released_events: rel_q,
                 short_events: short_q, long_events: long_q};
    if (item_i.do_scan) begin
      result_o.held_now        = held_v;
      result_o.pressed_events  = press_q | press_v;
      result_o.released_events = rel_q | rel_v;
      result_o.short_events    = short_q | short_v;
      result_o.long_events     = long_q | long_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      press_q <= '0;
      rel_q   <= '0;
      short_q <= '0;
      long_q  <= '0;
    end else if (take_i) begin
      held_q  <= result_o.held_now;
      press_q <= item_i.clear_pressed  ? '0 : result_o.pressed_events;
      rel_q   <= item_i.clear_released ? '0 : result_o.released_events;
      short_q <= item_i.clear_short    ? '0 : result_o.short_events;
      long_q  <= item_i.clear_long     ? '0 : result_o.long_events;
    end
  end

endmodule

// ----- src/bpc_checker.sv -----
// Port-level checker for the button press classifier, bound to the top
// level. Depends on bpc_pkg.
module bpc_checker
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  localparam logic [BTN_WIDTH-1:0] UNUSED = ~BTN_WIDTH'((1 << BUTTON_COUNT) - 1);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // a transfer into an empty buffer gives a result the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> out_valid_o)
    else $error("result missing one cycle after transfer");

  // input only backs up behind a pending result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input not ready with nothing pending");

  // buttons beyond the configured count never show up
  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((out_data_o.held_now | out_data_o.pressed_events |
      out_data_o.released_events | out_data_o.short_events |
      out_data_o.long_events) & UNUSED) == '0))
    else $error("unused button bit set in result");

endmodule

bind button_press_classifier bpc_checker #(
  .BUTTON_COUNT (BUTTON_COUNT)
) u_bpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
